// ===== hw/rtl/path_oram_access_controller_defines.svh =====
// Assertion shorthands used by the datapath, which checks its own logic.
// Each use names a label, a condition that starts the check, the condition
// that must then hold, and the message.
`ifndef PATH_ORAM_ACCESS_CONTROLLER_DEFINES_SVH
`define PATH_ORAM_ACCESS_CONTROLLER_DEFINES_SVH

`define POAC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define POAC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/poac_pkg.sv =====
package poac_pkg;

  localparam int IDX_W     = 10;
  localparam int IDX_SPACE = 1024;
  localparam int WDATA_W   = 64;
  localparam int LEAF_IN_W = 7;
  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 64;
  localparam int OUT_TUSER_W = 3;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_BAD_IDX = 2'd1;
  localparam logic [1:0] STAT_OVF     = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PMAP,
    ST_PATH_ADDR,
    ST_PATH_DATA,
    ST_SCAN,
    ST_SCAN_FIN,
    ST_EVICT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clr_step;
    logic accept;
    logic pmap_upd;
    logic path_put;
    logic scan_step;
    logic scan_fin;
    logic ev_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic bad_in;
    logic path_last;
    logic scan_last;
    logic ev_lvl_end;
    logic ev_lvl_zero;
  } sts_t;

endpackage

// ===== hw/rtl/poac_ctrl.sv =====
module poac_ctrl
  import poac_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  output logic out_tvalid,
  input  logic out_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_tready     = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = sts.bad_in ? ST_DONE : ST_PMAP;
        end
      end
      ST_PMAP: begin
        cmd.pmap_upd = 1'b1;
        state_nxt    = ST_PATH_ADDR;
      end
      ST_PATH_ADDR: state_nxt = ST_PATH_DATA;
      ST_PATH_DATA: begin
        cmd.path_put = 1'b1;
        state_nxt    = sts.path_last ? ST_SCAN : ST_PATH_ADDR;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) state_nxt = ST_SCAN_FIN;
      end
      ST_SCAN_FIN: begin
        cmd.scan_fin = 1'b1;
        state_nxt    = ST_EVICT;
      end
      ST_EVICT: begin
        cmd.ev_step = 1'b1;
        if (sts.ev_lvl_end && sts.ev_lvl_zero) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  assign out_tvalid = out_valid_r;

endmodule

// ===== hw/rtl/poac_dpath.sv =====
`include "path_oram_access_controller_defines.svh"
module poac_dpath
  import poac_pkg::*;
#(
  parameter int TREE_LEVELS      = 8,
  parameter int SLOTS_PER_BUCKET = 4,
  parameter int BLOCK_BITS       = 64,
  parameter int STASH_ENTRIES    = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cmd_t                   cmd,
  output sts_t                   sts,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tuser,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [OUT_TUSER_W-1:0] out_tuser
);

  localparam int LW    = TREE_LEVELS - 1;
  localparam int NB    = SLOTS_PER_BUCKET * ((1 << TREE_LEVELS) - 1);
  localparam int TAW   = $clog2(NB);
  localparam int LVW   = $clog2(TREE_LEVELS);
  localparam int SW    = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
  localparam int PW    = $clog2(STASH_ENTRIES);
  localparam int EW    = 1 + IDX_W + LW + BLOCK_BITS;
  localparam int CLR_N = (NB > IDX_SPACE) ? NB : IDX_SPACE;
  localparam int CW    = $clog2(CLR_N);

  logic [IDX_W-1:0]     in_idx;
  logic [WDATA_W-1:0]   in_wd;
  logic [LEAF_IN_W-1:0] in_leaf;
  logic [15:0]          leaf_ext;

  assign in_idx   = in_tdata[IDX_W-1:0];
  assign in_wd    = in_tdata[IDX_W +: WDATA_W];
  assign in_leaf  = in_tdata[IDX_W+WDATA_W +: LEAF_IN_W];
  assign leaf_ext = 16'(in_leaf);

  logic [EW-1:0] tree_mem [NB];
  logic [LW-1:0] pmap_mem [IDX_SPACE];
  logic [EW-1:0] tree_q_r;
  logic [LW-1:0] pmap_q_r;

  logic                  req_wr_r, bad_r, found_r, ovf_r, hit_r;
  logic [IDX_W-1:0]      idx_r;
  logic [BLOCK_BITS-1:0] wdata_r, rdata_r;
  logic [LW-1:0]         new_leaf_r, old_leaf_r;
  logic [LVW-1:0]        lvl_r;
  logic [SW-1:0]         slot_r, cnt_r;
  logic [PW-1:0]         ptr_r;
  logic [CW-1:0]         clr_cnt_r;

  logic [STASH_ENTRIES-1:0] st_v_r;
  logic [IDX_W-1:0]         st_id_r   [STASH_ENTRIES];
  logic [LW-1:0]            st_leaf_r [STASH_ENTRIES];
  logic [BLOCK_BITS-1:0]    st_data_r [STASH_ENTRIES];

  logic [WDATA_W-1:0]     out_data_r;
  logic                   out_found_r;
  logic [1:0]             out_status_r;

  int            sh_i, bkt_i;
  logic [TAW-1:0] path_addr;
  logic [SW-1:0]  off;
  logic           cur_v, cur_match, ev_match, ev_take, ptr_last;
  logic [PW-1:0]  free_idx;
  logic           free_any;
  logic           tq_v;
  logic [IDX_W-1:0]      tq_id;
  logic [LW-1:0]         tq_leaf;
  logic [BLOCK_BITS-1:0] tq_data;
  logic           clr_tree, clr_pmap;
  logic           tree_we, pmap_we;
  logic [TAW-1:0] tree_wa;
  logic [EW-1:0]  tree_wd;
  logic [IDX_W-1:0] pmap_wa;
  logic [LW-1:0]    pmap_wd;

  assign {tq_data, tq_leaf, tq_id, tq_v} = tree_q_r;

  always_comb begin
    off       = cmd.ev_step ? cnt_r : slot_r;
    sh_i      = LW - int'(lvl_r);
    bkt_i     = ((1 << int'(lvl_r)) - 1) + int'(old_leaf_r >> sh_i);
    path_addr = TAW'(bkt_i * SLOTS_PER_BUCKET + int'(off));
    cur_v     = st_v_r[ptr_r];
    cur_match = cur_v && (st_id_r[ptr_r] == idx_r);
    ev_match  = (st_leaf_r[ptr_r] >> sh_i) == (old_leaf_r >> sh_i);
    ev_take   = cmd.ev_step && cur_v && ev_match;
    ptr_last  = ptr_r == PW'(STASH_ENTRIES - 1);
  end

  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = STASH_ENTRIES - 1; i >= 0; i--) begin
      if (!st_v_r[i]) begin
        free_idx = PW'(i);
        free_any = 1'b1;
      end
    end
  end

  always_comb begin
    clr_tree = cmd.clr_step && (int'(clr_cnt_r) < NB);
    clr_pmap = cmd.clr_step && (int'(clr_cnt_r) < IDX_SPACE);
    tree_we  = clr_tree || cmd.path_put || ev_take;
    tree_wa  = cmd.clr_step ? clr_cnt_r[TAW-1:0] : path_addr;
    tree_wd  = ev_take ? {st_data_r[ptr_r], st_leaf_r[ptr_r], st_id_r[ptr_r], 1'b1} : '0;
    pmap_we  = clr_pmap || cmd.pmap_upd;
    pmap_wa  = cmd.clr_step ? clr_cnt_r[IDX_W-1:0] : idx_r;
    pmap_wd  = cmd.clr_step ? '0 : new_leaf_r;
  end

  always_ff @(posedge clk) begin
    if (tree_we) begin
      tree_mem[tree_wa] <= tree_wd;
    end
    tree_q_r <= tree_mem[path_addr];
    if (pmap_we) begin
      pmap_mem[pmap_wa] <= pmap_wd;
    end
    pmap_q_r <= pmap_mem[in_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      found_r   <= 1'b0;
      ovf_r     <= 1'b0;
      hit_r     <= 1'b0;
      bad_r     <= 1'b0;
      req_wr_r  <= 1'b0;
      lvl_r     <= '0;
      slot_r    <= '0;
      cnt_r     <= '0;
      ptr_r     <= '0;
      st_v_r    <= '0;
    end else begin
      if (cmd.clr_step) begin
        clr_cnt_r <= clr_cnt_r + CW'(1);
      end
      if (cmd.accept) begin
        req_wr_r   <= in_tuser;
        idx_r      <= in_idx;
        wdata_r    <= in_wd[BLOCK_BITS-1:0];
        new_leaf_r <= leaf_ext[LW-1:0];
        bad_r      <= sts.bad_in;
        found_r    <= 1'b0;
        ovf_r      <= 1'b0;
        hit_r      <= 1'b0;
        rdata_r    <= '0;
      end
      if (cmd.pmap_upd) begin
        old_leaf_r <= pmap_q_r;
        lvl_r      <= '0;
        slot_r     <= '0;
        ptr_r      <= '0;
      end
      if (cmd.path_put) begin
        if (tq_v) begin
          if (free_any) begin
            st_v_r[free_idx]    <= 1'b1;
            st_id_r[free_idx]   <= tq_id;
            st_leaf_r[free_idx] <= tq_leaf;
            st_data_r[free_idx] <= tq_data;
          end else begin
            ovf_r <= 1'b1;
          end
        end
        if (slot_r == SW'(SLOTS_PER_BUCKET - 1)) begin
          slot_r <= '0;
          lvl_r  <= lvl_r + LVW'(1);
        end else begin
          slot_r <= slot_r + SW'(1);
        end
      end
      if (cmd.scan_step) begin
        if (cur_match) begin
          st_leaf_r[ptr_r] <= new_leaf_r;
          if (req_wr_r) begin
            st_data_r[ptr_r] <= wdata_r;
            hit_r            <= 1'b1;
          end else begin
            rdata_r <= st_data_r[ptr_r];
            found_r <= 1'b1;
          end
        end
        ptr_r <= ptr_last ? '0 : ptr_r + PW'(1);
      end
      if (cmd.scan_fin) begin
        if (req_wr_r && !hit_r) begin
          if (free_any) begin
            st_v_r[free_idx]    <= 1'b1;
            st_id_r[free_idx]   <= idx_r;
            st_leaf_r[free_idx] <= new_leaf_r;
            st_data_r[free_idx] <= wdata_r;
          end else begin
            ovf_r <= 1'b1;
          end
        end
        lvl_r <= LVW'(TREE_LEVELS - 1);
        ptr_r <= '0;
        cnt_r <= '0;
      end
      if (cmd.ev_step) begin
        if (ev_take) begin
          st_v_r[ptr_r] <= 1'b0;
        end
        if (sts.ev_lvl_end) begin
          ptr_r <= '0;
          cnt_r <= '0;
          if (lvl_r != '0) begin
            lvl_r <= lvl_r - LVW'(1);
          end
        end else begin
          ptr_r <= ptr_r + PW'(1);
          if (ev_take) begin
            cnt_r <= cnt_r + SW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r   <= bad_r ? '0 : WDATA_W'(rdata_r);
      out_found_r  <= found_r && !bad_r;
      out_status_r <= bad_r ? STAT_BAD_IDX : (ovf_r ? STAT_OVF : STAT_OK);
    end
  end

  always_comb begin
    sts.clr_last    = clr_cnt_r == CW'(CLR_N - 1);
    sts.bad_in      = int'(in_idx) >= NB;
    sts.path_last   = (lvl_r == LVW'(TREE_LEVELS - 1)) &&
                      (slot_r == SW'(SLOTS_PER_BUCKET - 1));
    sts.scan_last   = ptr_last;
    sts.ev_lvl_end  = ptr_last || (ev_take && (cnt_r == SW'(SLOTS_PER_BUCKET - 1)));
    sts.ev_lvl_zero = lvl_r == '0;
  end

  assign out_tdata = out_data_r;
  assign out_tuser = {out_status_r, out_found_r};

  `POAC_ASSERT_IMPL(a_found_only_on_read, found_r, !req_wr_r, "found set on a write")
  `POAC_ASSERT_NEXT(a_write_takes_entry, cmd.scan_fin && req_wr_r && !hit_r && free_any,
    $countones(st_v_r) == $past($countones(st_v_r)) + 1, "written block not stashed")
  `POAC_ASSERT_NEXT(a_path_overflow, cmd.path_put && tq_v && !free_any, ovf_r,
    "dropped path block not flagged")

endmodule

// ===== hw/rtl/path_oram_access_controller.sv =====
// Path ORAM controller holding the tree, stash and position map on chip. Each
// transfer on the input is one access; it yields exactly one result transfer.
// After reset the block clears the position map and tree memories and takes
// no request meanwhile. A rejected index skips the access and goes straight
// to loading its result. Otherwise an access remaps the index, reads the path
// (one tree memory read and one write per slot), searches the stash, evicts
// from the leaf level up to the root, one stash entry examined per cycle, and
// loads the result, waiting while an earlier result still waits unaccepted.
// A new request is taken while the previous result still waits in the output
// register.
module path_oram_access_controller
  import poac_pkg::*;
#(
  parameter int TREE_LEVELS      = 8,
  parameter int SLOTS_PER_BUCKET = 4,
  parameter int BLOCK_BITS       = 64,
  parameter int STASH_ENTRIES    = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // block_index, write_data, new_leaf
  input  logic                   in_tuser,   // req_type
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // read_data
  output logic [OUT_TUSER_W-1:0] out_tuser   // found, status
);

  cmd_t cmd;
  sts_t sts;

  poac_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  poac_dpath #(
    .TREE_LEVELS      (TREE_LEVELS),
    .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET),
    .BLOCK_BITS       (BLOCK_BITS),
    .STASH_ENTRIES    (STASH_ENTRIES)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule
